[rtl/nxa_pkg.sv]
`timescale 1ns / 1ps

package nxa_pkg;

    // datapath widths of the shared divider
    localparam int NUM_W = 53;
    localparam int DEN_W = 38;
    localparam int Q_W   = 17;

    // fixed constants of the sigmoid and x/(x+1) branches
    localparam logic [16:0] LOG2E_Q16   = 17'd94548;
    localparam logic [39:0] EXP_LIM_Q24 = 40'd50 << 24;
    localparam logic [38:0] ONE_Q24     = 39'd1 << 24;

    // register indexes of the write port
    localparam logic [2:0] CFG_GAIN       = 3'd0;
    localparam logic [2:0] CFG_SIG_GAIN   = 3'd1;
    localparam logic [2:0] CFG_SIG_MULT   = 3'd2;
    localparam logic [2:0] CFG_INTERP_RNG = 3'd3;
    localparam logic [2:0] CFG_INTERP_VAL = 3'd4;
    localparam logic [2:0] CFG_GAIN_COR   = 3'd5;
    localparam logic [2:0] CFG_SPAN_INV   = 3'd6;

    // which branch of the activation an item takes
    typedef enum logic [1:0] {
        PATH_SIG,
        PATH_LIN,
        PATH_XX1
    } t_path;

    // side information that travels with an item through the divider
    typedef struct packed {
        t_path path;
        logic  neg;
    } t_tag;

    // configuration register group
    typedef struct packed {
        logic [17:0] gain;
        logic [19:0] sig_gain;
        logic [15:0] sig_mult;
        logic [15:0] interp_rng;
        logic [16:0] interp_val;
        logic [15:0] gain_cor;
        logic [19:0] span_inv;
    } t_cfg;

    // 2^(-k/16) in Q1.16, k = 0..16
    function automatic logic [16:0] pow2_neg(input logic [4:0] k);
        logic [16:0] v;
        begin
            case (k)
                5'd0:    v = 17'd65536;
                5'd1:    v = 17'd62757;
                5'd2:    v = 17'd60097;
                5'd3:    v = 17'd57549;
                5'd4:    v = 17'd55109;
                5'd5:    v = 17'd52773;
                5'd6:    v = 17'd50535;
                5'd7:    v = 17'd48393;
                5'd8:    v = 17'd46341;
                5'd9:    v = 17'd44376;
                5'd10:   v = 17'd42495;
                5'd11:   v = 17'd40693;
                5'd12:   v = 17'd38968;
                5'd13:   v = 17'd37316;
                5'd14:   v = 17'd35734;
                5'd15:   v = 17'd34219;
                default: v = 17'd32768;
            endcase
            return v;
        end
    endfunction

endpackage

[rtl/nxa_front.sv]
`timescale 1ns / 1ps

module nxa_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic signed [19:0]       i_x,
    input  nxa_pkg::t_cfg            i_cfg,
    output logic                     o_valid,
    output logic [nxa_pkg::NUM_W-1:0] o_num,
    output logic [nxa_pkg::DEN_W-1:0] o_den,
    output nxa_pkg::t_tag            o_tag
);

    // valid shift line, control only
    logic [4:0] r_v;

    // stage 0: input register
    logic signed [19:0] r0_x;

    // stage 1 registers
    logic [39:0]        r1_p;
    logic [38:0]        r1_cp;
    logic signed [35:0] r1_lp;
    logic [18:0]        r1_x;
    nxa_pkg::t_path     r1_path;

    // stage 2 registers
    logic [22:0]    r2_t;
    logic           r2_zero;
    logic [15:0]    r2_d;
    logic           r2_cneg;
    logic [35:0]    r2_lmag;
    logic           r2_lneg;
    logic [18:0]    r2_x;
    nxa_pkg::t_path r2_path;

    // stage 3 registers
    logic [16:0]    r3_e;
    logic [17:0]    r3_g;
    logic [35:0]    r3_lmag;
    logic           r3_lneg;
    logic [18:0]    r3_x;
    nxa_pkg::t_path r3_path;

    // stage 4 registers
    logic [32:0]    r4_snum;
    logic [17:0]    r4_sden;
    logic [36:0]    r4_y;
    logic [35:0]    r4_lmag;
    logic           r4_lneg;
    nxa_pkg::t_path r4_path;

    // stage 5 registers, divider operands
    logic [nxa_pkg::NUM_W-1:0] r5_num;
    logic [nxa_pkg::DEN_W-1:0] r5_den;
    nxa_pkg::t_tag             r5_tag;

    // stage 1 logic: branch select and first products
    logic [19:0]        w_mag;
    logic [18:0]        w_xpos;
    nxa_pkg::t_path     n1_path;
    logic [39:0]        n1_p;
    logic [38:0]        n1_cp;
    logic signed [35:0] n1_lp;

    always_comb begin
        w_mag  = 20'(-r0_x);
        w_xpos = r0_x[18:0];
        if (r0_x[19]) begin
            n1_path = nxa_pkg::PATH_SIG;
        end else if (w_xpos < {3'b000, i_cfg.interp_rng}) begin
            n1_path = nxa_pkg::PATH_LIN;
        end else begin
            n1_path = nxa_pkg::PATH_XX1;
        end
        n1_p  = 40'(w_mag) * 40'(i_cfg.sig_gain);
        n1_cp = 39'(w_xpos) * 39'(i_cfg.span_inv);
        n1_lp = $signed({17'b0, w_xpos}) *
                $signed({{19{i_cfg.interp_val[16]}}, i_cfg.interp_val});
    end

    // stage 2 logic: exponent scaling, correction factor, magnitude
    logic [21:0] w_e16;
    logic [38:0] w_tprod;
    logic [24:0] w_cv;
    logic [40:0] w_dprod;
    logic        n2_zero;
    logic        n2_cneg;
    logic [35:0] n2_lmag;

    always_comb begin
        n2_zero = r1_p > nxa_pkg::EXP_LIM_Q24;
        w_e16   = r1_p[29:8];
        w_tprod = 39'(w_e16) * 39'(nxa_pkg::LOG2E_Q16);
        n2_cneg = r1_cp > nxa_pkg::ONE_Q24;
        w_cv    = 25'(nxa_pkg::ONE_Q24 - r1_cp);
        w_dprod = 41'(i_cfg.gain_cor) * 41'(w_cv);
        n2_lmag = r1_lp[35] ? 36'(-r1_lp) : 36'(r1_lp);
    end

    // stage 3 logic: table interpolation of 2^-t, corrected gain
    logic [3:0]  w_k;
    logic [11:0] w_r;
    logic [6:0]  w_n;
    logic [16:0] w_tk;
    logic [16:0] w_tk1;
    logic [11:0] w_diff;
    logic [23:0] w_rprod;
    logic [16:0] w_pv;
    logic [16:0] n3_e;
    logic [34:0] w_gprod;
    logic [17:0] n3_g;

    always_comb begin
        w_n     = r2_t[22:16];
        w_k     = r2_t[15:12];
        w_r     = r2_t[11:0];
        w_tk    = nxa_pkg::pow2_neg({1'b0, w_k});
        w_tk1   = nxa_pkg::pow2_neg(5'({1'b0, w_k}) + 5'd1);
        w_diff  = 12'(w_tk - w_tk1);
        w_rprod = 24'(w_diff) * 24'(w_r);
        w_pv    = w_tk - 17'(w_rprod[23:12]);
        if (r2_zero || (w_n >= 7'd17)) begin
            n3_e = '0;
        end else begin
            n3_e = w_pv >> w_n[4:0];
        end
        w_gprod = 35'(i_cfg.gain) * 35'(17'h10000 - 17'(r2_d));
        n3_g    = r2_cneg ? i_cfg.gain : w_gprod[33:16];
    end

    // stage 5 logic: pick the divider operands of the branch
    logic [nxa_pkg::NUM_W-1:0] n5_num;
    logic [nxa_pkg::DEN_W-1:0] n5_den;

    always_comb begin
        case (r4_path)
            nxa_pkg::PATH_SIG: begin
                n5_num = nxa_pkg::NUM_W'(r4_snum);
                n5_den = nxa_pkg::DEN_W'(r4_sden);
            end
            nxa_pkg::PATH_LIN: begin
                n5_num = nxa_pkg::NUM_W'(r4_lmag);
                n5_den = nxa_pkg::DEN_W'(i_cfg.interp_rng);
            end
            default: begin
                n5_num = {r4_y, 16'b0};
                n5_den = nxa_pkg::DEN_W'(r4_y) + (nxa_pkg::DEN_W'(1) << 24);
            end
        endcase
    end

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            o_valid <= 1'b0;
        end else begin
            r_v     <= {r_v[3:0], i_valid};
            o_valid <= r_v[4];
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        r0_x    <= i_x;

        r1_p    <= n1_p;
        r1_cp   <= n1_cp;
        r1_lp   <= n1_lp;
        r1_x    <= w_xpos;
        r1_path <= n1_path;

        r2_t    <= w_tprod[38:16];
        r2_zero <= n2_zero;
        r2_d    <= w_dprod[39:24];
        r2_cneg <= n2_cneg;
        r2_lmag <= n2_lmag;
        r2_lneg <= r1_lp[35];
        r2_x    <= r1_x;
        r2_path <= r1_path;

        r3_e    <= n3_e;
        r3_g    <= n3_g;
        r3_lmag <= r2_lmag;
        r3_lneg <= r2_lneg;
        r3_x    <= r2_x;
        r3_path <= r2_path;

        r4_snum <= 33'(i_cfg.sig_mult) * 33'(r3_e);
        r4_sden <= 18'(r3_e) + 18'h10000;
        r4_y    <= 37'(r3_g) * 37'(r3_x);
        r4_lmag <= r3_lmag;
        r4_lneg <= r3_lneg;
        r4_path <= r3_path;

        r5_num      <= n5_num;
        r5_den      <= n5_den;
        r5_tag.path <= r4_path;
        r5_tag.neg  <= r4_lneg;
    end

    assign o_num = r5_num;
    assign o_den = r5_den;
    assign o_tag = r5_tag;

endmodule

[rtl/nxa_cell.sv]
`timescale 1ns / 1ps

module nxa_cell #(
    parameter int SHIFT = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [nxa_pkg::NUM_W-1:0] i_rem,
    input  logic [nxa_pkg::DEN_W-1:0] i_den,
    input  logic [nxa_pkg::Q_W-1:0]   i_q,
    input  nxa_pkg::t_tag             i_tag,
    output logic                      o_valid,
    output logic [nxa_pkg::NUM_W-1:0] o_rem,
    output logic [nxa_pkg::DEN_W-1:0] o_den,
    output logic [nxa_pkg::Q_W-1:0]   o_q,
    output nxa_pkg::t_tag             o_tag
);

    localparam int CMP_W = nxa_pkg::NUM_W + 2;

    logic [CMP_W-1:0]          w_ds;
    logic [nxa_pkg::NUM_W-1:0] n_rem;
    logic [nxa_pkg::Q_W-1:0]   n_q;
    logic                      r_valid;
    logic [nxa_pkg::NUM_W-1:0] r_rem;
    logic [nxa_pkg::DEN_W-1:0] r_den;
    logic [nxa_pkg::Q_W-1:0]   r_q;
    nxa_pkg::t_tag             r_tag;

    // one restoring step: try the shifted divisor
    always_comb begin
        w_ds  = CMP_W'(i_den) << SHIFT;
        n_rem = i_rem;
        n_q   = i_q;
        if (CMP_W'(i_rem) >= w_ds) begin
            n_rem      = i_rem - nxa_pkg::NUM_W'(w_ds);
            n_q[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= i_den;
        r_q   <= n_q;
        r_tag <= i_tag;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_q     = r_q;
    assign o_tag   = r_tag;

endmodule

[rtl/noisy_xx1_activation_top.sv]
`timescale 1ns / 1ps

// Noisy x/(x+1) activation. One request is taken on every clock (busy stays
// low), and each result is strobed by o_done for exactly one cycle; the
// receiver cannot stall, so it must take o_activation whenever o_done is high.
// A request passes through six front stages (input register, exponent/gain
// products, table lookup, operand select), a row of 17 divider cells, one
// quotient bit per cell, and the output register. The user must write registers
// through i_cfg_we/i_cfg_idx/i_cfg_data only while no request is in flight; the
// block does not enforce this. Indexes above 6 are ignored.

module noisy_xx1_activation_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [19:0] i_net_input,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_data,
    output logic        o_done,
    output logic [15:0] o_activation
);

    localparam int NCELL = nxa_pkg::Q_W;

    nxa_pkg::t_cfg r_cfg;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain       <= 18'd25600;
            r_cfg.sig_gain   <= 20'd153600;
            r_cfg.sig_mult   <= 16'd12422;
            r_cfg.interp_rng <= 16'd655;
            r_cfg.interp_val <= 17'd25191;
            r_cfg.gain_cor   <= 16'd6554;
            r_cfg.span_inv   <= 20'd5120;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                nxa_pkg::CFG_GAIN:       r_cfg.gain       <= i_cfg_data[17:0];
                nxa_pkg::CFG_SIG_GAIN:   r_cfg.sig_gain   <= i_cfg_data;
                nxa_pkg::CFG_SIG_MULT:   r_cfg.sig_mult   <= i_cfg_data[15:0];
                nxa_pkg::CFG_INTERP_RNG: r_cfg.interp_rng <= i_cfg_data[15:0];
                nxa_pkg::CFG_INTERP_VAL: r_cfg.interp_val <= i_cfg_data[16:0];
                nxa_pkg::CFG_GAIN_COR:   r_cfg.gain_cor   <= i_cfg_data[15:0];
                nxa_pkg::CFG_SPAN_INV:   r_cfg.span_inv   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // fully pipelined, never stalls
    assign busy = 1'b0;

    // front stages
    logic                      w_fv;
    logic [nxa_pkg::NUM_W-1:0] w_fnum;
    logic [nxa_pkg::DEN_W-1:0] w_fden;
    nxa_pkg::t_tag             w_ftag;

    nxa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_x     ($signed(i_net_input)),
        .i_cfg   (r_cfg),
        .o_valid (w_fv),
        .o_num   (w_fnum),
        .o_den   (w_fden),
        .o_tag   (w_ftag)
    );

    // divider row, msb quotient bit first
    logic                      w_v   [NCELL+1];
    logic [nxa_pkg::NUM_W-1:0] w_rem [NCELL+1];
    logic [nxa_pkg::DEN_W-1:0] w_den [NCELL+1];
    logic [nxa_pkg::Q_W-1:0]   w_q   [NCELL+1];
    nxa_pkg::t_tag             w_tag [NCELL+1];

    assign w_v[0]   = w_fv;
    assign w_rem[0] = w_fnum;
    assign w_den[0] = w_fden;
    assign w_q[0]   = '0;
    assign w_tag[0] = w_ftag;

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++) begin : g_cell
            nxa_cell #(
                .SHIFT (NCELL - 1 - gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_v[gi]),
                .i_rem   (w_rem[gi]),
                .i_den   (w_den[gi]),
                .i_q     (w_q[gi]),
                .i_tag   (w_tag[gi]),
                .o_valid (w_v[gi+1]),
                .o_rem   (w_rem[gi+1]),
                .o_den   (w_den[gi+1]),
                .o_q     (w_q[gi+1]),
                .o_tag   (w_tag[gi+1])
            );
        end
    endgenerate

    // final offset, sign and saturation
    logic [nxa_pkg::Q_W-1:0] w_qf;
    nxa_pkg::t_tag           w_tf;
    logic signed [18:0]      w_lin;
    logic [15:0]             n_act;
    logic                    r_done;
    logic [15:0]             r_act;

    always_comb begin
        w_qf = w_q[NCELL];
        w_tf = w_tag[NCELL];
        if (w_tf.neg) begin
            w_lin = $signed({4'b0, r_cfg.sig_mult[15:1]}) - $signed({2'b0, w_qf});
        end else begin
            w_lin = $signed({4'b0, r_cfg.sig_mult[15:1]}) + $signed({2'b0, w_qf});
        end
        case (w_tf.path)
            nxa_pkg::PATH_LIN: begin
                if (w_lin < 0) begin
                    n_act = '0;
                end else if (w_lin > 19'sd65535) begin
                    n_act = 16'hFFFF;
                end else begin
                    n_act = w_lin[15:0];
                end
            end
            default: begin
                n_act = w_qf[16] ? 16'hFFFF : w_qf[15:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_v[NCELL];
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act;
    end

    assign o_done       = r_done;
    assign o_activation = r_act;

endmodule

[tb/sv/noisy_xx1_activation_top_tb.sv]
`timescale 1ns / 1ps

module noisy_xx1_activation_top_tb;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASE_ITEMS = 170;

    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  idx;
        logic [19:0] data;
        logic [19:0] x;
        bit          chk;
        logic [15:0] expv;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [19:0] i_net_input;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [19:0] i_cfg_data;
    logic        o_done;
    logic [15:0] o_activation;

    // model copy of the registers
    longint cfg_gain, cfg_sig_gain, cfg_sig_mult, cfg_interp_rng;
    longint cfg_interp_val, cfg_gain_cor, cfg_span_inv;

    logic [15:0] act_expected[$];
    int          err_count = 0;
    int          cycles = 0;
    int          sent_count = 0;
    int          checked_count = 0;
    int          settings_count = 1;
    int          idle_pct = 8;

    longint exp2_tab[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                             46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219,
                             32768};

    t_row directed[] = '{
        '{ROW_ITEM, nxa_pkg::CFG_GAIN, 20'd0, 20'd0, 1, 16'd6211},
        '{ROW_ITEM, nxa_pkg::CFG_GAIN, 20'd0, 20'h80000, 1, 16'd0},
        '{ROW_ITEM, nxa_pkg::CFG_GAIN, 20'd0, 20'h7FFFF, 0, 16'd0},
        '{ROW_ITEM, nxa_pkg::CFG_GAIN, 20'd0, 20'hFFFFF, 0, 16'd0},
        '{ROW_ITEM, nxa_pkg::CFG_GAIN, 20'd0, 20'd654, 0, 16'd0},
        '{ROW_ITEM, nxa_pkg::CFG_GAIN, 20'd0, 20'd655, 0, 16'd0},
        '{ROW_ITEM, nxa_pkg::CFG_GAIN, 20'd0, 20'd1, 0, 16'd0},
        '{ROW_ITEM, nxa_pkg::CFG_GAIN, 20'd0, 20'd100000, 0, 16'd0},
        // sigmoid gain zero gives half the multiplier
        '{ROW_CFG, nxa_pkg::CFG_SIG_GAIN, 20'd0, 20'd0, 0, 16'd0},
        '{ROW_ITEM, nxa_pkg::CFG_GAIN, 20'd0, -20'sd300, 1, 16'd6211},
        '{ROW_ITEM, nxa_pkg::CFG_GAIN, 20'd0, 20'h80000, 1, 16'd6211},
        // gain zero flattens the x/(x+1) region
        '{ROW_CFG, nxa_pkg::CFG_GAIN, 20'd0, 20'd0, 0, 16'd0},
        '{ROW_ITEM, nxa_pkg::CFG_GAIN, 20'd0, 20'd1000, 1, 16'd0},
        // empty interpolation region
        '{ROW_CFG, nxa_pkg::CFG_INTERP_RNG, 20'd0, 20'd0, 0, 16'd0},
        '{ROW_ITEM, nxa_pkg::CFG_GAIN, 20'd0, 20'd0, 1, 16'd0},
        // span inverse zero, full gain reduction
        '{ROW_CFG, nxa_pkg::CFG_SPAN_INV, 20'd0, 20'd0, 0, 16'd0},
        '{ROW_CFG, nxa_pkg::CFG_GAIN, 20'd25600, 20'd0, 0, 16'd0},
        '{ROW_ITEM, nxa_pkg::CFG_GAIN, 20'd0, 20'd700, 0, 16'd0},
        // linear region leaving range at both ends
        '{ROW_CFG, nxa_pkg::CFG_INTERP_RNG, 20'hFFFF, 20'd0, 0, 16'd0},
        '{ROW_CFG, nxa_pkg::CFG_INTERP_VAL, 20'h0FFFF, 20'd0, 0, 16'd0},
        '{ROW_CFG, nxa_pkg::CFG_SIG_MULT, 20'hFFFF, 20'd0, 0, 16'd0},
        '{ROW_ITEM, nxa_pkg::CFG_GAIN, 20'd0, 20'd65534, 1, 16'd65535},
        '{ROW_ITEM, nxa_pkg::CFG_GAIN, 20'd0, 20'd0, 1, 16'd32767},
        '{ROW_CFG, nxa_pkg::CFG_INTERP_VAL, 20'h10000, 20'd0, 0, 16'd0},
        '{ROW_ITEM, nxa_pkg::CFG_GAIN, 20'd0, 20'd65534, 1, 16'd0},
        // write to an unused index changes nothing
        '{ROW_CFG, CFG_UNUSED, 20'hFFFFF, 20'd0, 0, 16'd0},
        '{ROW_ITEM, nxa_pkg::CFG_GAIN, 20'd0, 20'd0, 1, 16'd32767},
        '{ROW_CFG, nxa_pkg::CFG_GAIN_COR, 20'hFFFF, 20'd0, 0, 16'd0},
        '{ROW_ITEM, nxa_pkg::CFG_GAIN, 20'd0, 20'd70000, 0, 16'd0}
    };

    noisy_xx1_activation_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_net_input  (i_net_input),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_activation (o_activation)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // activation of one net input under the current registers
    function automatic logic [15:0] calc_activation(logic [19:0] x_raw);
        longint xs, mag, p, e16, t, n, f, k, r, pv, ev, res, c, g, d, y;
        xs = longint'(signed'(x_raw));
        if (xs < 0) begin
            mag = -xs;
            p = mag * cfg_sig_gain;
            if (p > (longint'(50) << 24)) begin
                res = 0;
            end else begin
                e16 = p >> 8;
                t = (e16 * 94548) >> 16;
                n = t >> 16;
                f = t & 16'hFFFF;
                k = f >> 12;
                r = f & 12'hFFF;
                pv = exp2_tab[k] - (((exp2_tab[k] - exp2_tab[k + 1]) * r) >> 12);
                ev = (n < 17) ? (pv >> n) : 0;
                res = (cfg_sig_mult * ev) / (65536 + ev);
            end
        end else if (xs < cfg_interp_rng) begin
            res = (cfg_sig_mult >> 1) + (xs * cfg_interp_val) / cfg_interp_rng;
            if (res < 0) res = 0;
            if (res > 65535) res = 65535;
        end else begin
            c = (longint'(1) << 24) - xs * cfg_span_inv;
            g = cfg_gain;
            if (c >= 0) begin
                d = (cfg_gain_cor * c) >> 24;
                g = (cfg_gain * (65536 - d)) >> 16;
            end
            y = g * xs;
            res = (y << 16) / (y + (longint'(1) << 24));
            if (res > 65535) res = 65535;
        end
        return res[15:0];
    endfunction

    // random net input, weighted toward the region borders
    function automatic logic [19:0] pick_net_input();
        longint v;
        case ($urandom_range(0, 3))
            0: v = longint'($urandom);
            1: v = ($urandom_range(0, 1) != 0) ? -longint'($urandom_range(1, 4096))
                                               : -longint'($urandom_range(1, 65536));
            2: v = (cfg_interp_rng > 0) ?
                   longint'($urandom_range(0, 32'(cfg_interp_rng - 1))) : 0;
            default: begin
                v = cfg_interp_rng + longint'($urandom_range(0, 8192));
                if (v > 524287) v = 524287;
            end
        endcase
        return v[19:0];
    endfunction

    // one request, held until accepted
    task automatic drive_item(logic [19:0] x, bit chk, logic [15:0] expv);
        start <= 1'b1;
        i_net_input <= x;
        do @(posedge i_clk); while (busy);
        act_expected.push_back(chk ? expv : calc_activation(x));
        sent_count++;
    endtask

    // wait until every result is back
    task automatic drain();
        start <= 1'b0;
        while (act_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write, model copy follows
    task automatic cfg_write(logic [2:0] idx, logic [19:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            nxa_pkg::CFG_GAIN:       cfg_gain = longint'(data[17:0]);
            nxa_pkg::CFG_SIG_GAIN:   cfg_sig_gain = longint'(data);
            nxa_pkg::CFG_SIG_MULT:   cfg_sig_mult = longint'(data[15:0]);
            nxa_pkg::CFG_INTERP_RNG: cfg_interp_rng = longint'(data[15:0]);
            nxa_pkg::CFG_INTERP_VAL: cfg_interp_val = longint'(signed'(data[16:0]));
            nxa_pkg::CFG_GAIN_COR:   cfg_gain_cor = longint'(data[15:0]);
            nxa_pkg::CFG_SPAN_INV:   cfg_span_inv = longint'(data);
            default: ;
        endcase
    endtask

    task automatic cfg_all(logic [19:0] g, logic [19:0] s, logic [19:0] m, logic [19:0] rng,
                           logic [19:0] v, logic [19:0] gc, logic [19:0] sp);
        drain();
        cfg_write(nxa_pkg::CFG_GAIN, g);
        cfg_write(nxa_pkg::CFG_SIG_GAIN, s);
        cfg_write(nxa_pkg::CFG_SIG_MULT, m);
        cfg_write(nxa_pkg::CFG_INTERP_RNG, rng);
        cfg_write(nxa_pkg::CFG_INTERP_VAL, v);
        cfg_write(nxa_pkg::CFG_GAIN_COR, gc);
        cfg_write(nxa_pkg::CFG_SPAN_INV, sp);
        settings_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (act_expected.size() == 0) begin
                $error("activation result with no request pending: %0d", o_activation);
                err_count++;
            end else begin
                logic [15:0] want;
                want = act_expected.pop_front();
                checked_count++;
                if (o_activation !== want) begin
                    $error("activation mismatch: expected %0d actual %0d", want, o_activation);
                    err_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // stimulus
    initial begin
        start = 1'b0;
        i_net_input = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        cfg_gain = 25600;
        cfg_sig_gain = 153600;
        cfg_sig_mult = 12422;
        cfg_interp_rng = 655;
        cfg_interp_val = 25191;
        cfg_gain_cor = 6554;
        cfg_span_inv = 5120;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG) begin
                drain();
                cfg_write(directed[i].idx, directed[i].data);
            end else begin
                drive_item(directed[i].x, directed[i].chk, directed[i].expv);
            end
        end

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: cfg_all(20'd25600, 20'd153600, 20'd12422, 20'd655, 20'd25191, 20'd6554,
                           20'd5120);
                1: cfg_all(20'hFFFFF, 20'hFFFFF, 20'hFFFF, 20'hFFFF, 20'h0FFFF, 20'hFFFF,
                           20'hFFFFF);
                2: cfg_all(20'd0, 20'd0, 20'd0, 20'd0, 20'h10000, 20'd0, 20'd0);
                3: cfg_all(20'($urandom), 20'($urandom_range(0, 400000)), 20'($urandom),
                           20'($urandom_range(1, 65535)), 20'($urandom), 20'($urandom),
                           20'($urandom_range(1, 20000)));
                default: cfg_all(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
                                 20'($urandom), 20'($urandom), 20'($urandom));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                idle_pct = (sent_count < 350) ? 8 : (sent_count < 700) ? 50 : 0;
                if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge i_clk);
                end
                drive_item(pick_net_input(), 0, 16'd0);
            end
        end

        // drain and report
        drain();
        $display("%0d requests sent across %0d register settings, %0d results checked",
                 sent_count, settings_count, checked_count);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
